FILE: rtl/core/rdc_pkg.sv
// Shared constants and helpers for the radix digit converter.
// Depends on nothing; used by radix_digit_converter.
`timescale 1ns / 1ps
package rdc_pkg;

  localparam int VALUE_WIDTH = 32;
  // The value port is always 32 bits; only the low VALUE_BITS take part.
  localparam int VALUE_BITS  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int STEP_W      = $clog2(VALUE_BITS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_BITS - 1);

  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int POS_W       = 5;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(48);  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A_BASE = CHAR_W'(55);  // 'A' - 10
  localparam logic [CHAR_W-1:0] CHAR_NONE   = CHAR_W'(0);

  // Map a remainder 0..35 to '0'..'9', 'A'..'Z'.
  function automatic logic [CHAR_W-1:0] digit_char_of(input logic [RADIX_W-1:0] rem);
    logic [CHAR_W-1:0] rem_ext;
    rem_ext = {1'b0, rem};
    if (rem < RADIX_W'(10)) begin
      digit_char_of = CHAR_ZERO + rem_ext;
    end else begin
      digit_char_of = CHAR_A_BASE + rem_ext;
    end
  endfunction

endpackage

FILE: rtl/core/radix_digit_converter.sv
// Radix digit converter: turns an unsigned value into ASCII digits, LSD first.
// A bad radix or a zero value gives its single digit the cycle after start.
// Otherwise a restoring divider, one bit per cycle over all VALUE_BITS bits, gives
// each digit as a remainder and then divides the quotient again.
// Throughput: one item at a time; busy is high while the divider runs.
// Reset (rst, synchronous): idle, no digit strobe. The receiver cannot stall.
// Depends on rdc_pkg.
`timescale 1ns / 1ps
module radix_digit_converter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [31:0]                       value,
  input  logic [rdc_pkg::RADIX_W-1:0]       radix,
  output logic                              busy,
  output logic                              digit_valid,
  output logic [rdc_pkg::CHAR_W-1:0]        digit_char,
  output logic [rdc_pkg::POS_W-1:0]         digit_pos,
  output logic                              last,
  output logic                              bad_radix
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_t;

  state_t                            state;
  logic [rdc_pkg::VALUE_BITS-1:0]    quotient_left;
  logic [rdc_pkg::RADIX_W-1:0]       rem;
  logic [rdc_pkg::RADIX_W-1:0]       radix_held;
  logic [rdc_pkg::STEP_W-1:0]        step;
  logic [rdc_pkg::POS_W-1:0]         digit_count;

  logic                              accept;
  logic                              radix_ok;
  logic [rdc_pkg::VALUE_BITS-1:0]    value_in;
  logic [rdc_pkg::RADIX_W:0]         trial;
  logic                              fits;
  logic [rdc_pkg::RADIX_W-1:0]       rem_next;
  logic [rdc_pkg::VALUE_BITS-1:0]    quotient_next;

  assign busy     = (state == ST_DIV);
  assign accept   = start && !busy;
  assign radix_ok = (radix >= rdc_pkg::RADIX_MIN) && (radix <= rdc_pkg::RADIX_MAX);
  assign value_in = value[rdc_pkg::VALUE_BITS-1:0];

  // One restoring division step: shift the next dividend bit into the remainder.
  always_comb begin
    trial         = {rem, quotient_left[rdc_pkg::VALUE_BITS-1]};
    fits          = (trial >= {1'b0, radix_held});
    rem_next      = fits ? rdc_pkg::RADIX_W'(trial - {1'b0, radix_held})
                         : trial[rdc_pkg::RADIX_W-1:0];
    quotient_next = {quotient_left[rdc_pkg::VALUE_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      digit_valid   <= 1'b0;
      digit_char    <= '0;
      digit_pos     <= '0;
      last          <= 1'b0;
      bad_radix     <= 1'b0;
      quotient_left <= '0;
      radix_held    <= '0;
      rem           <= '0;
      step          <= '0;
      digit_count   <= '0;
    end else begin
      digit_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!radix_ok) begin
              digit_valid <= 1'b1;
              digit_char  <= rdc_pkg::CHAR_NONE;
              digit_pos   <= '0;
              last        <= 1'b1;
              bad_radix   <= 1'b1;
            end else if (value_in == '0) begin
              digit_valid <= 1'b1;
              digit_char  <= rdc_pkg::CHAR_ZERO;
              digit_pos   <= '0;
              last        <= 1'b1;
              bad_radix   <= 1'b0;
            end else begin
              quotient_left <= value_in;
              radix_held    <= radix;
              rem           <= '0;
              step          <= '0;
              digit_count   <= '0;
              state         <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          quotient_left <= quotient_next;
          if (step == rdc_pkg::LAST_STEP) begin
            // Division done: emit the remainder, then divide the quotient again unless it is zero.
            digit_valid <= 1'b1;
            digit_char  <= rdc_pkg::digit_char_of(rem_next);
            digit_pos   <= digit_count;
            last        <= (quotient_next == '0);
            bad_radix   <= 1'b0;
            digit_count <= digit_count + rdc_pkg::POS_W'(1);
            rem         <= '0;
            step        <= '0;
            if (quotient_next == '0) begin
              state <= ST_IDLE;
            end
          end else begin
            rem  <= rem_next;
            step <= step + rdc_pkg::STEP_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
